/* sv/link_health_state_monitor_assert.svh */
// assertion macros for the link health state monitor
// no dependencies; taken in by the top level with an include
`ifndef LINK_HEALTH_STATE_MONITOR_ASSERT_SVH
`define LINK_HEALTH_STATE_MONITOR_ASSERT_SVH

// clocked property, masked while reset is high
`define LHSM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define LHSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/lhsm_pkg.sv */
// shared types and constants of the link health state monitor
// no dependencies; used by lhsm_secs and link_health_state_monitor
`timescale 1ns / 1ps

package lhsm_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int NOW_W = 32;
   localparam int RTT_W = 16;
   localparam int CSR_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int SECS_W = 23;

   typedef enum logic [1:0] {
      HEALTH_OK         = 2'd0,
      HEALTH_DEGRADED   = 2'd1,
      HEALTH_DOWN       = 2'd2,
      HEALTH_RECOVERING = 2'd3
   } health_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_GATEWAY_STALE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVICE_STALE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATENCY_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECONNECT_WIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RTO_HOLD      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_WIN   = 3'd5;

   localparam logic [CSR_W-1:0] GATEWAY_STALE_RESET = 16'd4000;
   localparam logic [CSR_W-1:0] SERVICE_STALE_RESET = 16'd4000;
   localparam logic [CSR_W-1:0] LATENCY_LIMIT_RESET = 16'd80;
   localparam logic [CSR_W-1:0] RECONNECT_WIN_RESET = 16'd5000;
   localparam logic [CSR_W-1:0] RTO_HOLD_RESET      = 16'd5000;
   localparam logic [CSR_W-1:0] STARTUP_WIN_RESET   = 16'd2000;

   // span / 1000 == (span >> 3) / 125, reciprocal of 125 scaled by 2^37
   localparam int DIV_PRE_SHIFT = 3;
   localparam int DIV_X_W = 30;
   localparam int DIV_M_W = 31;
   localparam int DIV_SHIFT = 37;
   localparam int DIV_PROD_W = DIV_X_W + DIV_M_W;
   localparam logic [DIV_M_W-1:0] DIV_M = 31'd1099511627;
   localparam int DIV_D = 125;
   // spans at or above 2^23 seconds saturate
   localparam int SAT_SPAN_W = 34;
   localparam logic [63:0] SAT_SPAN = 64'd8388608000;
   localparam logic [SECS_W-1:0] SECS_MAX = {SECS_W{1'b1}};

endpackage

/* sv/link_health_state_monitor.sv */
// link health state monitor top level: input beat register, state update, outage timing
// depends on lhsm_pkg, lhsm_secs and link_health_state_monitor_assert.svh
// four pipeline registers carry a req beat: input beat, stage 1, stage 2 and output register
// throughput: one beat per cycle while rsp_tready is high; the seconds divide is a
//    registered reciprocal multiply in lhsm_secs followed by a one-step correction
// reset: synchronous, active high; config returns to defaults, health to RECOVERING
//    with the startup window running, the pipeline empties
`timescale 1ns / 1ps
`include "link_health_state_monitor_assert.svh"

module link_health_state_monitor #(
   parameter int TIME_WIDTH = lhsm_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // now_ms[31:0], link_up[32], service_ok[33], service_rtt_ms[49:34],
   // gateway_ok[50], gateway_rtt_ms[66:51], zero fill
   input  logic [71:0]                      req_tdata,
   // is_sample
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // health[1:0], gateway_taken[2], outage_seconds[25:3], outage_valid[26],
   // showing_recovery[27], zero fill
   output logic [31:0]                      rsp_tdata,
   input  logic                             csr_we,
   input  logic [lhsm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lhsm_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int TW = TIME_WIDTH;
   localparam int RW = lhsm_pkg::RTT_W;
   localparam int CW = lhsm_pkg::CSR_W;
   localparam int SW = lhsm_pkg::SECS_W;

   // config
   logic [CW-1:0] gw_stale_ff, svc_stale_ff, lat_limit_ff;
   logic [CW-1:0] reconnect_ff, rto_hold_ff;

   // pipeline handshake
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   logic rdy1, rdy2, rdy3;
   logic acc0, adv1, adv2, adv3, adv4;

   // input beat register
   logic [TW-1:0] s0_now_ff;
   logic          s0_link_ff, s0_sample_ff, s0_sok_ff, s0_gok_ff;
   logic [RW-1:0] s0_srtt_ff, s0_grtt_ff;

   // monitor state
   logic                 prev_link_ff, prev_link_in;
   logic [TW-1:0]        recover_ff, recover_in;
   logic [TW-1:0]        gw_time_ff, gw_time_in;
   logic                 gw_ok_ff, gw_ok_in;
   logic [RW-1:0]        gw_rtt_ff, gw_rtt_in;
   logic [TW-1:0]        svc_time_ff, svc_time_in;
   logic                 svc_ok_ff, svc_ok_in;
   logic [RW-1:0]        svc_rtt_ff, svc_rtt_in;
   logic                 was_up_ff, was_up_in;
   logic [TW-1:0]        down_since_ff, down_since_in;
   logic                 dsv_ff, dsv_in;
   logic [TW-1:0]        hold_ff, hold_in;
   logic                 seen_ff, seen_in;
   logic                 tog_ff, tog_in;
   lhsm_pkg::health_type cur_health_ff, cur_health_in;

   // per-beat results of the state pass
   logic          recov_in, taken_in, show_in;
   logic [TW-1:0] span_in;

   logic [TW-1:0] d_hold, d_recover, age_gw, age_svc;
   logic          in_hold, in_recover, gw_stale, svc_stale, lat_high;

   // stage 1 and 2 payload
   lhsm_pkg::health_type s1_health_ff, s2_health_ff;
   logic                 s1_taken_ff, s1_seen_ff, s1_show_ff, s1_recov_ff;
   logic                 s2_taken_ff, s2_seen_ff, s2_show_ff, s2_recov_ff;
   logic [TW-1:0]        s1_span_ff;

   // output register
   lhsm_pkg::health_type o_health_ff;
   logic                 o_taken_ff, o_seen_ff, o_show_ff;
   logic [SW-1:0]        outage_secs_ff;
   logic [SW-1:0]        secs;

   // handshake
   always_comb begin
      adv4       = v3_ff && rsp_tready;
      rdy3       = !v3_ff || rsp_tready;
      adv3       = v2_ff && rdy3;
      rdy2       = !v2_ff || rdy3;
      adv2       = v1_ff && rdy2;
      rdy1       = !v1_ff || rdy2;
      adv1       = v0_ff && rdy1;
      req_tready = !v0_ff || rdy1;
      acc0       = req_tvalid && req_tready;
      v0_in      = acc0 ? 1'b1 : (adv1 ? 1'b0 : v0_ff);
      v1_in      = adv1 ? 1'b1 : (adv2 ? 1'b0 : v1_ff);
      v2_in      = adv2 ? 1'b1 : (adv3 ? 1'b0 : v2_ff);
      v3_in      = adv3 ? 1'b1 : (adv4 ? 1'b0 : v3_ff);
   end

   // one pass of the monitor on the registered beat
   always_comb begin
      prev_link_in  = s0_link_ff;
      recover_in    = recover_ff;
      gw_time_in    = gw_time_ff;
      gw_ok_in      = gw_ok_ff;
      gw_rtt_in     = gw_rtt_ff;
      svc_time_in   = svc_time_ff;
      svc_ok_in     = svc_ok_ff;
      svc_rtt_in    = svc_rtt_ff;
      was_up_in     = was_up_ff;
      down_since_in = down_since_ff;
      dsv_in        = dsv_ff;
      hold_in       = hold_ff;
      seen_in       = seen_ff;
      tog_in        = tog_ff;
      recov_in      = 1'b0;
      taken_in      = 1'b0;
      span_in       = '0;

      if (!prev_link_ff && s0_link_ff) begin
         recover_in = s0_now_ff + TW'(reconnect_ff);
      end

      if (s0_link_ff && s0_sample_ff) begin
         svc_ok_in  = s0_sok_ff;
         svc_rtt_in = s0_sok_ff ? s0_srtt_ff : '0;
         if (s0_sok_ff) begin
            svc_time_in = s0_now_ff;
         end
         tog_in = !tog_ff;
         if (tog_in) begin
            taken_in  = 1'b1;
            gw_ok_in  = s0_gok_ff;
            gw_rtt_in = s0_gok_ff ? s0_grtt_ff : '0;
            if (s0_gok_ff) begin
               gw_time_in = s0_now_ff;
            end
         end
         if (was_up_ff && !s0_sok_ff) begin
            down_since_in = s0_now_ff;
            dsv_in        = 1'b1;
         end
         if (!was_up_ff && s0_sok_ff) begin
            recov_in = 1'b1;
            span_in  = dsv_ff ? s0_now_ff - down_since_ff : '0;
            seen_in  = 1'b1;
            hold_in  = s0_now_ff + TW'(rto_hold_ff);
         end
         was_up_in = s0_sok_ff;
      end

      // wrap-safe compares against the updated state
      d_hold     = hold_in - s0_now_ff;
      d_recover  = recover_in - s0_now_ff;
      age_gw     = s0_now_ff - gw_time_in;
      age_svc    = s0_now_ff - svc_time_in;
      in_hold    = seen_in && (d_hold != '0) && !d_hold[TW-1];
      in_recover = (d_recover != '0) && !d_recover[TW-1];
      gw_stale   = age_gw > TW'(gw_stale_ff);
      svc_stale  = age_svc > TW'(svc_stale_ff);
      lat_high   = (gw_ok_in && (gw_rtt_in >= lat_limit_ff)) ||
                   (svc_ok_in && (svc_rtt_in >= lat_limit_ff));
      show_in    = in_hold;

      if (!s0_link_ff) begin
         cur_health_in = lhsm_pkg::HEALTH_DOWN;
      end else if (!s0_sample_ff) begin
         cur_health_in = cur_health_ff;
      end else if (in_hold || in_recover) begin
         cur_health_in = lhsm_pkg::HEALTH_RECOVERING;
      end else if (gw_stale) begin
         cur_health_in = lhsm_pkg::HEALTH_DOWN;
      end else if (svc_stale || lat_high) begin
         cur_health_in = lhsm_pkg::HEALTH_DEGRADED;
      end else begin
         cur_health_in = lhsm_pkg::HEALTH_OK;
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_stale_ff  <= lhsm_pkg::GATEWAY_STALE_RESET;
         svc_stale_ff <= lhsm_pkg::SERVICE_STALE_RESET;
         lat_limit_ff <= lhsm_pkg::LATENCY_LIMIT_RESET;
         reconnect_ff <= lhsm_pkg::RECONNECT_WIN_RESET;
         rto_hold_ff  <= lhsm_pkg::RTO_HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lhsm_pkg::CSR_GATEWAY_STALE: gw_stale_ff  <= csr_wdata;
            lhsm_pkg::CSR_SERVICE_STALE: svc_stale_ff <= csr_wdata;
            lhsm_pkg::CSR_LATENCY_LIMIT: lat_limit_ff <= csr_wdata;
            lhsm_pkg::CSR_RECONNECT_WIN: reconnect_ff <= csr_wdata;
            lhsm_pkg::CSR_RTO_HOLD:      rto_hold_ff  <= csr_wdata;
            // startup window only matters at reset, where it is back at its default
            lhsm_pkg::CSR_STARTUP_WIN:   ;
            default: ;
         endcase
      end
   end

   // control and monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         prev_link_ff  <= 1'b1;
         recover_ff    <= TW'(lhsm_pkg::STARTUP_WIN_RESET);
         gw_time_ff    <= '0;
         gw_ok_ff      <= 1'b0;
         gw_rtt_ff     <= '0;
         svc_time_ff   <= '0;
         svc_ok_ff     <= 1'b0;
         svc_rtt_ff    <= '0;
         was_up_ff     <= 1'b1;
         down_since_ff <= '0;
         dsv_ff        <= 1'b0;
         hold_ff       <= '0;
         seen_ff       <= 1'b0;
         tog_ff        <= 1'b0;
         cur_health_ff <= lhsm_pkg::HEALTH_RECOVERING;
         outage_secs_ff <= '0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         if (adv1) begin
            prev_link_ff  <= prev_link_in;
            recover_ff    <= recover_in;
            gw_time_ff    <= gw_time_in;
            gw_ok_ff      <= gw_ok_in;
            gw_rtt_ff     <= gw_rtt_in;
            svc_time_ff   <= svc_time_in;
            svc_ok_ff     <= svc_ok_in;
            svc_rtt_ff    <= svc_rtt_in;
            was_up_ff     <= was_up_in;
            down_since_ff <= down_since_in;
            dsv_ff        <= dsv_in;
            hold_ff       <= hold_in;
            seen_ff       <= seen_in;
            tog_ff        <= tog_in;
            cur_health_ff <= cur_health_in;
         end
         if (adv3 && s2_recov_ff) begin
            outage_secs_ff <= secs;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (acc0) begin
         s0_now_ff    <= TW'(req_tdata[31:0]);
         s0_link_ff   <= req_tdata[32];
         s0_sample_ff <= req_tuser;
         s0_sok_ff    <= req_tdata[33];
         s0_srtt_ff   <= req_tdata[49:34];
         s0_gok_ff    <= req_tdata[50];
         s0_grtt_ff   <= req_tdata[66:51];
      end
      if (adv1) begin
         s1_health_ff <= cur_health_in;
         s1_taken_ff  <= taken_in;
         s1_seen_ff   <= seen_in;
         s1_show_ff   <= show_in;
         s1_recov_ff  <= recov_in;
         s1_span_ff   <= span_in;
      end
      if (adv2) begin
         s2_health_ff <= s1_health_ff;
         s2_taken_ff  <= s1_taken_ff;
         s2_seen_ff   <= s1_seen_ff;
         s2_show_ff   <= s1_show_ff;
         s2_recov_ff  <= s1_recov_ff;
      end
      if (adv3) begin
         o_health_ff <= s2_health_ff;
         o_taken_ff  <= s2_taken_ff;
         o_seen_ff   <= s2_seen_ff;
         o_show_ff   <= s2_show_ff;
      end
   end

   lhsm_secs #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_secs (
      .clock(clock),
      .load (adv2),
      .span (s1_span_ff),
      .secs (secs)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {4'b0, o_show_ff, o_seen_ff, outage_secs_ff, o_taken_ff, o_health_ff};

   `LHSM_ASSERT(a_link_down_is_down, clock, reset, adv1 && !s0_link_ff |=> s1_health_ff == lhsm_pkg::HEALTH_DOWN, "link down beat not reported DOWN")
   `LHSM_ASSERT(a_taken_on_toggle, clock, reset, adv1 |=> s1_taken_ff == (tog_ff && !$past(tog_ff)), "gateway taken without toggle rising")
   `LHSM_ASSERT(a_show_needs_outage, clock, reset, v1_ff && s1_show_ff |-> s1_seen_ff, "recovery shown before any outage")
   `LHSM_ASSERT(a_stall_only_when_full, clock, reset, !req_tready |-> v0_ff && v1_ff && v2_ff && v3_ff, "input stalled with a free stage")

endmodule

/* sv/lhsm_secs.sv */
// outage span in ms to whole seconds, two stages: reciprocal multiply, then correction
// depends on lhsm_pkg
`timescale 1ns / 1ps

module lhsm_secs #(
   parameter int TIME_WIDTH = lhsm_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [TIME_WIDTH-1:0]       span,
   output logic [lhsm_pkg::SECS_W-1:0] secs
);

   localparam int EXT_W = (TIME_WIDTH > lhsm_pkg::SAT_SPAN_W) ? TIME_WIDTH
                                                              : lhsm_pkg::SAT_SPAN_W;
   localparam int Q_W = lhsm_pkg::DIV_PROD_W - lhsm_pkg::DIV_SHIFT;

   logic [EXT_W-1:0]                  span_ext;
   logic [lhsm_pkg::DIV_X_W-1:0]      x_in;
   logic                              sat_in;
   logic [lhsm_pkg::DIV_PROD_W-1:0]   prod_in;

   logic [lhsm_pkg::DIV_X_W-1:0]      x_ff;
   logic                              sat_ff;
   logic [lhsm_pkg::DIV_PROD_W-1:0]   prod_ff;

   logic [Q_W-1:0]                    q0;
   logic [lhsm_pkg::DIV_X_W-1:0]      rem;
   logic [Q_W-1:0]                    q;

   always_comb begin
      span_ext = EXT_W'(span);
      sat_in   = span_ext >= EXT_W'(lhsm_pkg::SAT_SPAN);
      x_in     = span_ext[lhsm_pkg::DIV_PRE_SHIFT +: lhsm_pkg::DIV_X_W];
      prod_in  = lhsm_pkg::DIV_PROD_W'(x_in) * lhsm_pkg::DIV_PROD_W'(lhsm_pkg::DIV_M);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= x_in;
         sat_ff  <= sat_in;
         prod_ff <= prod_in;
      end
   end

   // estimate is exact or one low
   always_comb begin
      q0   = prod_ff[lhsm_pkg::DIV_PROD_W-1:lhsm_pkg::DIV_SHIFT];
      rem  = x_ff - lhsm_pkg::DIV_X_W'(lhsm_pkg::DIV_X_W'(q0) *
                                       lhsm_pkg::DIV_X_W'(lhsm_pkg::DIV_D));
      q    = (rem >= lhsm_pkg::DIV_X_W'(lhsm_pkg::DIV_D)) ? q0 + Q_W'(1) : q0;
      secs = sat_ff ? lhsm_pkg::SECS_MAX : q[lhsm_pkg::SECS_W-1:0];
   end

endmodule

/* dv/testbench.sv */
// self-checking testbench for link_health_state_monitor: directed passes, then random phases
// depends on lhsm_pkg and the link_health_state_monitor rtl; prediction is a local copy of the state
`timescale 1ns / 1ps

module testbench;

   localparam int SETTLE_CYCLES = 8;
   localparam logic [lhsm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd6;
   localparam logic [lhsm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   typedef enum logic [1:0] {
      OP_PASS,
      OP_CSR_WRITE,
      OP_DRAIN
   } op_kind_type;

   typedef struct packed {
      logic [15:0] gw_rtt;
      logic        gw_ok;
      logic [15:0] svc_rtt;
      logic        svc_ok;
      logic        link;
      logic [31:0] now;
   } pass_type;

   typedef struct packed {
      op_kind_type                        kind;
      pass_type                           pass;
      logic                               is_sample;
      logic [lhsm_pkg::CSR_INDEX_W-1:0]   index;
      logic [lhsm_pkg::CSR_W-1:0]         value;
      logic [4:0]                         gap;
   } op_type;

   typedef struct packed {
      logic                        showing;
      logic                        outage_valid;
      logic [lhsm_pkg::SECS_W-1:0] secs;
      logic                        taken;
      lhsm_pkg::health_type        health;
   } health_verdict_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [71:0]                      req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [31:0]                      rsp_tdata;
   logic                             csr_we = 1'b0;
   logic [lhsm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lhsm_pkg::CSR_W-1:0]       csr_wdata = '0;

   op_type             bus_script[$];
   health_verdict_type health_due[$];
   int unsigned        mismatches = 0;
   int unsigned        results_seen = 0;
   int unsigned        gap_count = 0;
   int unsigned        quiet_count = 0;
   int unsigned        stall_left = 0;
   int unsigned        ready_mode = 0;
   int unsigned        sender_mode = 0;

   // stimulus generator state
   logic [31:0] gen_now;
   logic        gen_link;
   logic        gen_service;
   logic        gen_gateway;
   int unsigned gen_latency;

   // predicted block state and limits
   logic                        lnk_prev;
   logic [31:0]                 reconnect_until;
   logic [31:0]                 gw_ok_at;
   logic                        gw_ok_last;
   logic [15:0]                 gw_rtt_last;
   logic [31:0]                 svc_ok_at;
   logic                        svc_ok_last;
   logic [15:0]                 svc_rtt_last;
   logic                        svc_up;
   logic [31:0]                 outage_start;
   logic                        outage_start_valid;
   logic [31:0]                 hold_end;
   logic [lhsm_pkg::SECS_W-1:0] outage_secs_held;
   logic                        outage_seen_held;
   logic                        gw_turn;
   lhsm_pkg::health_type        health_held;
   logic [lhsm_pkg::CSR_W-1:0]  gw_stale_lim;
   logic [lhsm_pkg::CSR_W-1:0]  svc_stale_lim;
   logic [lhsm_pkg::CSR_W-1:0]  lat_lim;
   logic [lhsm_pkg::CSR_W-1:0]  reconnect_ms;
   logic [lhsm_pkg::CSR_W-1:0]  hold_ms;

   link_health_state_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // wrap-safe: mark lies strictly ahead of now by less than half the range
   function automatic logic precedes(input logic [31:0] now, input logic [31:0] mark);
      logic [31:0] d;
      d = mark - now;
      return (d != 32'd0) && !d[31];
   endfunction

   function automatic logic aged(input logic [31:0] now, input logic [31:0] last,
                                 input logic [lhsm_pkg::CSR_W-1:0] lim);
      logic [31:0] age;
      age = now - last;
      return age > {16'd0, lim};
   endfunction

   function automatic int unsigned draw_wait(input int unsigned mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
         default: return $urandom_range(0, 16);
      endcase
   endfunction

   task automatic clear_model();
      gw_stale_lim       = lhsm_pkg::GATEWAY_STALE_RESET;
      svc_stale_lim      = lhsm_pkg::SERVICE_STALE_RESET;
      lat_lim            = lhsm_pkg::LATENCY_LIMIT_RESET;
      reconnect_ms       = lhsm_pkg::RECONNECT_WIN_RESET;
      hold_ms            = lhsm_pkg::RTO_HOLD_RESET;
      lnk_prev           = 1'b1;
      reconnect_until    = {16'd0, lhsm_pkg::STARTUP_WIN_RESET};
      gw_ok_at           = '0;
      gw_ok_last         = 1'b0;
      gw_rtt_last        = '0;
      svc_ok_at          = '0;
      svc_ok_last        = 1'b0;
      svc_rtt_last       = '0;
      svc_up             = 1'b1;
      outage_start       = '0;
      outage_start_valid = 1'b0;
      hold_end           = '0;
      outage_secs_held   = '0;
      outage_seen_held   = 1'b0;
      gw_turn            = 1'b0;
      health_held        = lhsm_pkg::HEALTH_RECOVERING;
   endtask

   task automatic track_link_health(input pass_type p, input logic is_sample,
                                    output health_verdict_type v);
      logic        taken;
      logic [31:0] span;
      logic [31:0] span_secs;
      taken = 1'b0;
      if (!lnk_prev && p.link)
         reconnect_until = p.now + {16'd0, reconnect_ms};
      lnk_prev = p.link;
      if (!p.link) begin
         health_held = lhsm_pkg::HEALTH_DOWN;
      end else if (is_sample) begin
         svc_ok_last  = p.svc_ok;
         svc_rtt_last = p.svc_ok ? p.svc_rtt : 16'd0;
         if (p.svc_ok)
            svc_ok_at = p.now;
         gw_turn = ~gw_turn;
         if (gw_turn) begin
            taken       = 1'b1;
            gw_ok_last  = p.gw_ok;
            gw_rtt_last = p.gw_ok ? p.gw_rtt : 16'd0;
            if (p.gw_ok)
               gw_ok_at = p.now;
         end
         // outage opens on the up to down edge, closes on recovery
         if (svc_up && !svc_ok_last) begin
            outage_start       = p.now;
            outage_start_valid = 1'b1;
         end
         if (!svc_up && svc_ok_last) begin
            span             = outage_start_valid ? p.now - outage_start : 32'd0;
            span_secs        = span / 32'd1000;
            outage_secs_held = (span_secs > {9'd0, lhsm_pkg::SECS_MAX}) ?
                               lhsm_pkg::SECS_MAX : span_secs[lhsm_pkg::SECS_W-1:0];
            outage_seen_held = 1'b1;
            hold_end         = p.now + {16'd0, hold_ms};
         end
         svc_up = svc_ok_last;
         if (outage_seen_held && precedes(p.now, hold_end))
            health_held = lhsm_pkg::HEALTH_RECOVERING;
         else if (precedes(p.now, reconnect_until))
            health_held = lhsm_pkg::HEALTH_RECOVERING;
         else if (aged(p.now, gw_ok_at, gw_stale_lim))
            health_held = lhsm_pkg::HEALTH_DOWN;
         else if (aged(p.now, svc_ok_at, svc_stale_lim))
            health_held = lhsm_pkg::HEALTH_DEGRADED;
         else if ((gw_ok_last && gw_rtt_last >= lat_lim) ||
                  (svc_ok_last && svc_rtt_last >= lat_lim))
            health_held = lhsm_pkg::HEALTH_DEGRADED;
         else
            health_held = lhsm_pkg::HEALTH_OK;
      end
      v.health       = health_held;
      v.taken        = taken;
      v.secs         = outage_secs_held;
      v.outage_valid = outage_seen_held;
      v.showing      = outage_seen_held && precedes(p.now, hold_end);
   endtask

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_pass(input logic [31:0] stamp, input logic link, input logic is_sample,
                             input logic s_ok, input logic [15:0] s_rtt,
                             input logic g_ok, input logic [15:0] g_rtt);
      op_type op;
      op              = '0;
      op.kind         = OP_PASS;
      op.pass.now     = stamp;
      op.pass.link    = link;
      op.pass.svc_ok  = s_ok;
      op.pass.svc_rtt = s_rtt;
      op.pass.gw_ok   = g_ok;
      op.pass.gw_rtt  = g_rtt;
      op.is_sample    = is_sample;
      op.gap          = 5'(draw_wait(sender_mode));
      bus_script.push_back(op);
   endtask

   task automatic queue_csr(input logic [lhsm_pkg::CSR_INDEX_W-1:0] index,
                            input logic [lhsm_pkg::CSR_W-1:0] value);
      op_type op;
      op       = '0;
      op.kind  = OP_CSR_WRITE;
      op.index = index;
      op.value = value;
      bus_script.push_back(op);
   endtask

   task automatic queue_drain();
      op_type op;
      op      = '0;
      op.kind = OP_DRAIN;
      bus_script.push_back(op);
   endtask

   function automatic logic [15:0] pick_rtt();
      int unsigned r;
      case ($urandom_range(0, 7))
         0: r = $urandom_range(0, 65535);
         1: r = gen_latency;
         2: r = (gen_latency == 0) ? 0 : gen_latency - 1;
         default: r = $urandom_range(0, gen_latency * 2 + 1);
      endcase
      return (r > 65535) ? 16'hFFFF : r[15:0];
   endfunction

   function automatic logic [lhsm_pkg::CSR_W-1:0] pick_limit(input int phase,
                                                             input int unsigned lo,
                                                             input int unsigned hi);
      if (phase == 0)
         return '0;
      if (phase == 1)
         return '1;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return lhsm_pkg::CSR_W'($urandom_range(0, 65535));
         default: return lhsm_pkg::CSR_W'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic queue_random_pass();
      logic s_ok;
      logic g_ok;
      case ($urandom_range(0, 19))
         0: gen_now = $urandom;
         1, 2: gen_now += $urandom_range(3000, 70000);
         default: gen_now += $urandom_range(0, 1200);
      endcase
      if ($urandom_range(0, 29) == 0)
         gen_link = ~gen_link;
      if ($urandom_range(0, 11) == 0)
         gen_service = ~gen_service;
      if ($urandom_range(0, 19) == 0)
         gen_gateway = ~gen_gateway;
      s_ok = ($urandom_range(0, 15) == 0) ? ~gen_service : gen_service;
      g_ok = ($urandom_range(0, 15) == 0) ? ~gen_gateway : gen_gateway;
      queue_pass(gen_now, gen_link, $urandom_range(0, 2) != 0, s_ok, pick_rtt(), g_ok, pick_rtt());
   endtask

   // request side: passes, register writes and drain pauses in script order
   always @(posedge clock) begin : drive_requests
      logic   valid_next;
      logic   we_next;
      op_type head;
      if (reset) begin
         req_tvalid  <= 1'b0;
         csr_we      <= 1'b0;
         gap_count   = 0;
         quiet_count = 0;
      end else begin
         we_next    = 1'b0;
         valid_next = req_tvalid && !req_tready;
         if (!valid_next && bus_script.size() != 0) begin
            head = bus_script[0];
            case (head.kind)
               OP_PASS: begin
                  if (gap_count < head.gap) begin
                     gap_count++;
                  end else begin
                     gap_count  = 0;
                     valid_next = 1'b1;
                     req_tdata  <= {5'd0, head.pass};
                     req_tuser  <= head.is_sample;
                     void'(bus_script.pop_front());
                  end
               end
               OP_CSR_WRITE: begin
                  we_next   = 1'b1;
                  csr_index <= head.index;
                  csr_wdata <= head.value;
                  void'(bus_script.pop_front());
               end
               default: begin
                  if (req_tvalid || health_due.size() != 0) begin
                     quiet_count = 0;
                  end else if (quiet_count < SETTLE_CYCLES) begin
                     quiet_count++;
                  end else begin
                     quiet_count = 0;
                     void'(bus_script.pop_front());
                  end
               end
            endcase
         end
         req_tvalid <= valid_next;
         csr_we     <= we_next;
      end
   end

   // result side: register writes and request beats feed the prediction, result beats are checked
   always @(posedge clock) begin : watch_results
      health_verdict_type want;
      health_verdict_type fresh;
      if (reset) begin
         clear_model();
         health_due.delete();
         stall_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (health_due.size() == 0) begin
               $display("%0t: result beat expected none, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = health_due.pop_front();
               check_field("health", want.health, rsp_tdata[1:0]);
               check_field("gateway_taken", want.taken, rsp_tdata[2]);
               check_field("outage_seconds", want.secs, rsp_tdata[25:3]);
               check_field("outage_valid", want.outage_valid, rsp_tdata[26]);
               check_field("showing_recovery", want.showing, rsp_tdata[27]);
               check_field("zero fill", 32'd0, rsp_tdata[31:28]);
            end
            results_seen++;
            if (results_seen % 50 == 0)
               ready_mode = $urandom_range(0, 2);
            stall_left = draw_wait(ready_mode);
         end
         if (csr_we) begin
            case (csr_index)
               lhsm_pkg::CSR_GATEWAY_STALE: gw_stale_lim = csr_wdata;
               lhsm_pkg::CSR_SERVICE_STALE: svc_stale_lim = csr_wdata;
               lhsm_pkg::CSR_LATENCY_LIMIT: lat_lim = csr_wdata;
               lhsm_pkg::CSR_RECONNECT_WIN: reconnect_ms = csr_wdata;
               lhsm_pkg::CSR_RTO_HOLD:      hold_ms = csr_wdata;
               // only the reset value of the startup window is ever used
               lhsm_pkg::CSR_STARTUP_WIN:   ;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            track_link_health(req_tdata[66:0], req_tuser, fresh);
            health_due.push_back(fresh);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      gen_now     = 32'd20000;
      gen_link    = 1'b1;
      gen_service = 1'b1;
      gen_gateway = 1'b1;
      gen_latency = lhsm_pkg::LATENCY_LIMIT_RESET;
      sender_mode = 1;

      // writes past the last register are dropped
      queue_drain();
      queue_csr(CSR_SPARE_FIRST, 16'hFFFF);
      queue_csr(CSR_SPARE_LAST, 16'h0000);

      // startup window, then the defaults walked through their edges
      queue_pass(32'd0, 1'b1, 1'b1, 1'b1, 16'd10, 1'b1, 16'd10);
      queue_pass(32'd100, 1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF);
      queue_pass(32'd2000, 1'b1, 1'b1, 1'b1, 16'd79, 1'b0, 16'd0);
      queue_pass(32'd2500, 1'b1, 1'b1, 1'b1, 16'd80, 1'b1, 16'hFFFF);
      // failed probes carry junk round trips
      queue_pass(32'd3000, 1'b1, 1'b1, 1'b0, 16'hFFFF, 1'b0, 16'hFFFF);
      queue_pass(32'd6500, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 16'hFFFF);
      // gateway age one past the limit
      queue_pass(32'd6501, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b1, 16'd5);
      queue_pass(32'd9500, 1'b1, 1'b1, 1'b1, 16'd5, 1'b1, 16'd5);
      // link drop and return
      queue_pass(32'd9600, 1'b0, 1'b1, 1'b1, 16'd5, 1'b1, 16'd5);
      queue_pass(32'd9700, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
      queue_pass(32'd9800, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0);
      queue_pass(32'd9900, 1'b1, 1'b1, 1'b1, 16'd1, 1'b1, 16'd1);
      queue_pass(32'd14900, 1'b1, 1'b1, 1'b1, 16'd1, 1'b1, 16'd1);
      queue_pass(32'd15000, 1'b1, 1'b1, 1'b1, 16'd0, 1'b1, 16'd0);
      // outage across the time wrap
      queue_pass(32'hFFFF_FF00, 1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
      queue_pass(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16'h1234, 1'b1, 16'd3);
      queue_pass(32'h0000_0BB8, 1'b1, 1'b1, 1'b1, 16'd0, 1'b1, 16'd0);
      // half-range jumps and a near full-range outage
      queue_pass(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 16'd2, 1'b1, 16'd2);
      queue_pass(32'h8000_0C00, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0);
      queue_pass(32'h7FFF_0000, 1'b1, 1'b1, 1'b1, 16'd7, 1'b1, 16'd7);
      queue_pass(32'h7FFF_0001, 1'b1, 1'b0, 1'b1, 16'd7, 1'b1, 16'd7);

      for (int phase = 0; phase < 10; phase++) begin
         queue_drain();
         gen_latency = pick_limit(phase, 0, 300);
         queue_csr(lhsm_pkg::CSR_GATEWAY_STALE, pick_limit(phase, 500, 6000));
         queue_csr(lhsm_pkg::CSR_SERVICE_STALE, pick_limit(phase, 500, 6000));
         queue_csr(lhsm_pkg::CSR_LATENCY_LIMIT, lhsm_pkg::CSR_W'(gen_latency));
         queue_csr(lhsm_pkg::CSR_RECONNECT_WIN, pick_limit(phase, 0, 8000));
         queue_csr(lhsm_pkg::CSR_RTO_HOLD, pick_limit(phase, 0, 8000));
         queue_csr(lhsm_pkg::CSR_STARTUP_WIN, pick_limit(phase, 0, 8000));
         if ($urandom_range(0, 2) == 0)
            queue_csr($urandom_range(0, 1) ? CSR_SPARE_FIRST : CSR_SPARE_LAST, 16'($urandom));
         sender_mode = $urandom_range(0, 2);
         for (int n = 0; n < 93; n++) begin
            if ($urandom_range(0, 59) == 0)
               queue_drain();
            queue_random_pass();
         end
      end
      queue_drain();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (bus_script.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/lhsm_pkg.sv
sv/lhsm_secs.sv
sv/link_health_state_monitor.sv
dv/testbench.sv
